// ===== rtl/core/sglu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sglu_pkg
// Shared types, register codes and helpers of the stereo gain and linear
// upsampler.
// ----------------------------------------------------------------------------
package sglu_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 10;
    localparam int MODE_W   = 2;
    localparam int PROD_W   = 26;   // 16-bit signed sample times 10-bit gain
    localparam int SCALED_W = 24;   // product after dropping two fraction bits
    localparam int IDX_W    = 2;
    localparam int DATA_W   = 10;
    localparam int NFRM     = 4;    // output frames per item at most
    localparam int CNT_W    = 3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SCALED_W-1:0] t_scaled;
    typedef logic [GAIN_W-1:0]          t_gain;
    typedef logic [MODE_W-1:0]          t_mode;
    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic [DATA_W-1:0]          t_data;
    typedef logic [CNT_W-1:0]           t_cnt;

    localparam t_mode MODE_X1 = 2'd0;
    localparam t_mode MODE_X2 = 2'd1;
    localparam t_mode MODE_X4 = 2'd2;

    localparam t_idx REG_GAIN = 2'd0;
    localparam t_idx REG_MODE = 2'd1;
    localparam t_idx REG_MONO = 2'd2;

    localparam t_gain GAIN_RESET = 10'd4;

    localparam t_sample SAMPLE_MAX = 16'sh7FFF;
    localparam t_sample SAMPLE_MIN = 16'sh8000;

    // control from the top level to each lane
    typedef struct packed {
        logic s1_load;   // capture a new product
        logic hist_we;   // current scaled value becomes the history
    } t_lane_ctl;

    // saturated points of one channel: quarter, mid, three-quarter, frame
    typedef struct packed {
        t_sample q1;
        t_sample m;
        t_sample q3;
        t_sample s;
    } t_pts;

    function automatic t_sample sat16(input t_scaled v);
        t_sample r;
        if (v[SCALED_W-1:SAMPLE_W-1] == {(SCALED_W-SAMPLE_W+1){v[SCALED_W-1]}}) begin
            r = v[SAMPLE_W-1:0];
        end else begin
            r = v[SCALED_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/sglu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sglu_if
// Valid/ready channels of the upsampler: input frames, output frames and
// register writes.
// ----------------------------------------------------------------------------
interface sglu_in_if;
    logic               valid;
    logic               ready;
    sglu_pkg::t_sample  left_sample;
    sglu_pkg::t_sample  right_sample;

    modport source (output valid, left_sample, right_sample, input ready);
    modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface sglu_out_if;
    logic               valid;
    logic               ready;
    sglu_pkg::t_sample  out_left;
    sglu_pkg::t_sample  out_right;
    logic               run_last;

    modport source (output valid, out_left, out_right, run_last, input ready);
    modport sink   (input valid, out_left, out_right, run_last, output ready);
endinterface

interface sglu_cfg_if;
    logic             valid;
    logic             ready;
    sglu_pkg::t_idx   index;
    sglu_pkg::t_data  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sglu_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sglu_lane
// One channel: gain multiply, history of the last scaled value and the
// interpolated points between history and current value.
// ----------------------------------------------------------------------------
module sglu_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sglu_pkg::t_lane_ctl  i_ctl,
    input  sglu_pkg::t_sample    i_sample,
    input  sglu_pkg::t_gain      i_gain,
    output sglu_pkg::t_pts       o_pts
);
    import sglu_pkg::*;

    logic signed [PROD_W:0]   w_prod;
    logic signed [PROD_W-1:0] r_prod;
    t_scaled                  r_hist;
    t_scaled                  w_s;
    t_scaled                  w_m;
    t_scaled                  w_q1;
    t_scaled                  w_q3;

    // floor of the mean; sum carried one bit wider
    function automatic t_scaled avg(input t_scaled a, input t_scaled b);
        logic signed [SCALED_W:0] sum;
        sum = {a[SCALED_W-1], a} + {b[SCALED_W-1], b};
        return sum[SCALED_W:1];
    endfunction

    assign w_prod = i_sample * $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_load) begin
            r_prod <= w_prod[PROD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_ctl.hist_we) begin
            r_hist <= w_s;
        end
    end

    // arithmetic shift right by two drops the gain fraction
    assign w_s  = r_prod[PROD_W-1:2];
    assign w_m  = avg(r_hist, w_s);
    assign w_q1 = avg(r_hist, w_m);
    assign w_q3 = avg(w_m, w_s);

    assign o_pts.q1 = sat16(w_q1);
    assign o_pts.m  = sat16(w_m);
    assign o_pts.q3 = sat16(w_q3);
    assign o_pts.s  = sat16(w_s);

endmodule

// ===== rtl/core/sglu_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sglu_merge
// Joins the two lanes into stereo frames; a small frame buffer plays them out
// one per cycle while o_out.ready holds, its head entry the output register.
// ----------------------------------------------------------------------------
module sglu_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  sglu_pkg::t_mode    i_mode,
    input  sglu_pkg::t_pts     i_left,
    input  sglu_pkg::t_pts     i_right,
    output logic               o_load_ready,
    sglu_out_if.source         o_out
);
    import sglu_pkg::*;

    t_sample r_buf_l [NFRM];
    t_sample r_buf_r [NFRM];
    t_sample n_buf_l [NFRM];
    t_sample n_buf_r [NFRM];
    t_cnt    r_cnt;
    t_cnt    n_cnt;
    logic    w_out_acc;

    assign w_out_acc    = o_out.valid && o_out.ready;
    // take new frames only once the last pending one leaves
    assign o_load_ready = (r_cnt == '0) || ((r_cnt == t_cnt'(1)) && w_out_acc);

    always_comb begin
        n_buf_l = r_buf_l;
        n_buf_r = r_buf_r;
        n_cnt   = r_cnt;
        if (i_load) begin
            case (i_mode)
                MODE_X1: begin
                    n_buf_l[0] = i_left.s;
                    n_buf_r[0] = i_right.s;
                    n_cnt      = t_cnt'(1);
                end
                MODE_X2: begin
                    n_buf_l[0] = i_left.m;
                    n_buf_r[0] = i_right.m;
                    n_buf_l[1] = i_left.s;
                    n_buf_r[1] = i_right.s;
                    n_cnt      = t_cnt'(2);
                end
                MODE_X4: begin
                    n_buf_l[0] = i_left.q1;
                    n_buf_r[0] = i_right.q1;
                    n_buf_l[1] = i_left.m;
                    n_buf_r[1] = i_right.m;
                    n_buf_l[2] = i_left.q3;
                    n_buf_r[2] = i_right.q3;
                    n_buf_l[3] = i_left.s;
                    n_buf_r[3] = i_right.s;
                    n_cnt      = t_cnt'(NFRM);
                end
                default: begin
                    n_cnt = '0;
                end
            endcase
        end else if (w_out_acc) begin
            for (int k = 0; k < NFRM - 1; k++) begin
                n_buf_l[k] = r_buf_l[k+1];
                n_buf_r[k] = r_buf_r[k+1];
            end
            n_cnt = r_cnt - t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf_l <= n_buf_l;
        r_buf_r <= n_buf_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_out.valid     = (r_cnt != '0);
    assign o_out.out_left  = r_buf_l[0];
    assign o_out.out_right = r_buf_r[0];
    assign o_out.run_last  = (r_cnt == t_cnt'(1));

endmodule

// ===== rtl/core/stereo_gain_linear_upsampler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_gain_linear_upsampler_unit
// Stereo gain stage with x1/x2/x4 linear interpolation and 16-bit saturation.
// ----------------------------------------------------------------------------
// Each input item is a stereo frame; left and right run in two identical lanes
// (multiply, then interpolate against the held previous frame) and a merge
// stage plays the resulting frames out one per cycle while the output takes
// them. An item yields one output frame in x1, two in x2 and four in x4 mode:
// the frame buffer of the merge stage emits one frame per cycle while the
// output is ready and takes the next item's frames as its last pending frame
// leaves, so a steady stream leaves no gap between items. The first frame of
// an item is presented once its products have passed the stage 1 register
// and been loaded into the merge buffer. Mode 3 produces no frames. Register
// writes are always taken and must only happen while no item is in flight.
module stereo_gain_linear_upsampler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sglu_in_if.sink     i_in,
    sglu_out_if.source  o_out,
    sglu_cfg_if.sink    i_cfg
);
    import sglu_pkg::*;

    t_gain      r_gain;
    t_mode      r_mode;
    logic       r_mono;
    logic       r_s1_valid;
    logic       w_in_acc;
    logic       w_s2_load;
    logic       w_merge_ready;
    t_lane_ctl  w_ctl;
    t_sample    w_right_src;
    t_pts       w_pts_l;
    t_pts       w_pts_r;

    // register file
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_mode <= MODE_X1;
            r_mono <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_GAIN: r_gain <= i_cfg.data[GAIN_W-1:0];
                REG_MODE: r_mode <= i_cfg.data[MODE_W-1:0];
                REG_MONO: r_mono <= i_cfg.data[0];
                default:  ;
            endcase
        end
    end

    // stage 1 holds the products, stage 2 hands points to the merge buffer
    assign w_s2_load  = r_s1_valid && w_merge_ready;
    assign i_in.ready = !r_s1_valid || w_merge_ready;
    assign w_in_acc   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    assign w_ctl.s1_load = w_in_acc;
    assign w_ctl.hist_we = w_s2_load && (r_mode inside {MODE_X2, MODE_X4});
    assign w_right_src   = r_mono ? i_in.left_sample : i_in.right_sample;

    sglu_lane u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_in.left_sample),
        .i_gain   (r_gain),
        .o_pts    (w_pts_l)
    );

    sglu_lane u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (w_right_src),
        .i_gain   (r_gain),
        .o_pts    (w_pts_r)
    );

    sglu_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_s2_load),
        .i_mode       (r_mode),
        .i_left       (w_pts_l),
        .i_right      (w_pts_r),
        .o_load_ready (w_merge_ready),
        .o_out        (o_out)
    );

    a_x1_single_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_load && (r_mode == MODE_X1) |=> o_out.valid && o_out.run_last)
        else $error("x1 item did not yield a single last frame");

    a_x4_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_load && (r_mode == MODE_X4) |=> o_out.valid && !o_out.run_last)
        else $error("x4 item first frame flagged last");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && r_s1_valid |-> w_merge_ready)
        else $error("stage 1 overwritten while full");

    a_buffer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.run_last |-> !w_merge_ready)
        else $error("merge took new frames with more than one pending");

endmodule
